// File: design/pendulum_ode_integrator_macros.svh
// ----------------------------------------------------------------------------
// Pendulum integrator assertion macros
// Short forms for the concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PENDULUM_ODE_INTEGRATOR_MACROS_SVH
`define PENDULUM_ODE_INTEGRATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pendulum_ode_integrator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pendulum_ode_integrator: next-cycle check failed");

`endif

// File: design/pdi_pkg.sv
// ----------------------------------------------------------------------------
// Pendulum integrator package
// Widths, fixed-point constants, command types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package pdi_pkg;

   // Number formats.
   localparam int DATA_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int SINE_ITERS  = 16;
   localparam int CORDIC_FRAC = 30;
   localparam int CORDIC_W    = CORDIC_FRAC + 4;
   localparam int DVD_W       = DATA_W + FRAC_W;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int Q_W         = PROD_W - FRAC_W;
   localparam int MOD_W       = 19;
   localparam int IDX_W       = 20;
   localparam int CNT_W       = 21;
   localparam int SUBS_W      = 16;
   localparam int UREG_W      = 31;
   localparam int CSR_IDX_W   = 3;
   localparam int OP_W        = 3;
   localparam int DIV_CNT_W   = $clog2(DVD_W);
   localparam int ROT_CNT_W   = $clog2(SINE_ITERS);

   // Angles in the data format, rounded from the exact values.
   localparam logic [MOD_W-1:0] PI_Q      = 19'd205887;
   localparam logic [MOD_W-1:0] TWO_PI_Q  = 19'd411775;
   localparam logic [MOD_W-1:0] HALF_PI_Q = 19'd102944;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Configuration register indices.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRAVITY        = 3'd0,
      CSR_ROD_LENGTH     = 3'd1,
      CSR_START_POSITION = 3'd2,
      CSR_START_VELOCITY = 3'd3,
      CSR_SAMPLE_STEP    = 3'd4,
      CSR_SUBDIVISIONS   = 3'd5,
      CSR_METHOD         = 3'd6,
      CSR_SAMPLE_COUNT   = 3'd7
   } csr_index_type;

   // Operand and destination selectors of the shared multiply-accumulate path.
   typedef enum logic [1:0] {MA_GRAV, MA_ACC, MA_VEL, MA_V2} mul_a_type;
   typedef enum logic [1:0] {MB_SIN, MB_DT, MB_HDT} mul_b_type;
   typedef enum logic [2:0] {D_ACC, D_VEL, D_POS, D_V2, D_SM} dest_type;
   typedef enum logic {B_VEL, B_POS} base_type;
   typedef enum logic {AS_POS, AS_SM} acc_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_start;
      logic        div_start;
      logic        div_ang;
      acc_src_type acc_src;
      logic        cordic_start;
      logic        sine_load;
      logic        mul_en;
      mul_a_type   mul_a;
      mul_b_type   mul_b;
      logic        fin_en;
      dest_type    fin_dest;
      base_type    fin_base;
      logic        dt_load;
      logic        snap;
      logic        out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic cordic_done;
   } sts_type;

   // Arctangent of two to the minus idx, with CORDIC_FRAC fraction bits.
   function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [5:0] idx);
      logic [CORDIC_W-1:0] pow;
      logic signed [CORDIC_W-1:0] val;
      pow = CORDIC_W'(1) << (6'(CORDIC_FRAC) - idx);
      case (idx)
         6'd0: val = 34'sd843314857;
         6'd1: val = 34'sd497837829;
         6'd2: val = 34'sd263043837;
         6'd3: val = 34'sd133525159;
         6'd4: val = 34'sd67021687;
         6'd5: val = 34'sd33543516;
         6'd6: val = 34'sd16775851;
         6'd7: val = 34'sd8388437;
         6'd8: val = 34'sd4194283;
         6'd9: val = 34'sd2097149;
         default: val = (idx <= 6'(CORDIC_FRAC)) ? $signed(pow) : '0;
      endcase
      return val;
   endfunction

endpackage

// File: design/pendulum_ode_integrator.sv
// Work: a restart first divides the step by the subdivisions; each request runs
//   S substeps (S = subdivisions), with one sine for Euler, two for midpoint.
// Throughput: one item at a time; each sine costs an angle division and 16
//   CORDIC rotations. The next request is taken once the result sits in the
//   output register.
// Reset: synchronous; state zeroed, registers to their defaults, no result held.
// ----------------------------------------------------------------------------
// Pendulum ODE integrator
// Configuration registers and the controller and datapath of the integrator.
// ----------------------------------------------------------------------------
module pendulum_ode_integrator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pdi_pkg::DATA_W-1:0]     rsp_position,
   output logic                                  rsp_last_sample,
   output logic                                  rsp_saturated,
   input  logic                                  csr_write_en,
   input  logic [pdi_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pdi_pkg::DATA_W-1:0]            csr_wdata
);
   import pdi_pkg::*;

   logic [UREG_W-1:0]        gravity_ff, gravity_in;
   logic [UREG_W-1:0]        rod_ff, rod_in;
   logic signed [DATA_W-1:0] spos_ff, spos_in;
   logic signed [DATA_W-1:0] svel_ff, svel_in;
   logic [UREG_W-1:0]        step_ff, step_in;
   logic [SUBS_W-1:0]        subs_ff, subs_in;
   logic                     method_ff, method_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   cmd_type cmd;
   sts_type sts;

   // Configuration register writes.
   always_comb begin
      gravity_in = gravity_ff;
      rod_in     = rod_ff;
      spos_in    = spos_ff;
      svel_in    = svel_ff;
      step_in    = step_ff;
      subs_in    = subs_ff;
      method_in  = method_ff;
      count_in   = count_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRAVITY:        gravity_in = csr_wdata[UREG_W-1:0];
            CSR_ROD_LENGTH:     rod_in     = csr_wdata[UREG_W-1:0];
            CSR_START_POSITION: spos_in    = $signed(csr_wdata);
            CSR_START_VELOCITY: svel_in    = $signed(csr_wdata);
            CSR_SAMPLE_STEP:    step_in    = csr_wdata[UREG_W-1:0];
            CSR_SUBDIVISIONS:   subs_in    = csr_wdata[SUBS_W-1:0];
            CSR_METHOD:         method_in  = csr_wdata[0];
            CSR_SAMPLE_COUNT:   count_in   = csr_wdata[CNT_W-1:0];
            default:            method_in  = method_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= UREG_W'(642908);
         rod_ff     <= UREG_W'(655360);
         spos_ff    <= DATA_W'(65536);
         svel_ff    <= '0;
         step_ff    <= UREG_W'(655);
         subs_ff    <= SUBS_W'(1);
         method_ff  <= 1'b0;
         count_ff   <= CNT_W'(1024);
      end else begin
         gravity_ff <= gravity_in;
         rod_ff     <= rod_in;
         spos_ff    <= spos_in;
         svel_ff    <= svel_in;
         step_ff    <= step_in;
         subs_ff    <= subs_in;
         method_ff  <= method_in;
         count_ff   <= count_in;
      end
   end

   pdi_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .method       (method_ff),
      .subdivisions (subs_ff),
      .cmd          (cmd),
      .sts          (sts)
   );

   pdi_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .gravity         (gravity_ff),
      .rod_length      (rod_ff),
      .start_position  (spos_ff),
      .start_velocity  (svel_ff),
      .sample_step     (step_ff),
      .subdivisions    (subs_ff),
      .sample_count    (count_ff),
      .rsp_position    (rsp_position),
      .rsp_last_sample (rsp_last_sample),
      .rsp_saturated   (rsp_saturated)
   );

endmodule

// File: design/pdi_divider.sv
// ----------------------------------------------------------------------------
// Pendulum integrator divider
// Restoring divider, one quotient bit a cycle, that also keeps the quotient
// reduced modulo two pi as its bits appear.
// ----------------------------------------------------------------------------
module pdi_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pdi_pkg::DVD_W-1:0]    dividend,
   input  logic [pdi_pkg::DATA_W-1:0]   divisor,
   output logic                         done,
   output logic [pdi_pkg::DVD_W-1:0]    quotient,
   output logic [pdi_pkg::MOD_W-1:0]    residue
);
   import pdi_pkg::*;

   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DATA_W-1:0]    den_ff, den_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [MOD_W-1:0]     mod_ff, mod_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DATA_W:0]      rem_sh;
   logic                 rem_ge;
   logic [MOD_W:0]       mod_sh;

   // One restoring step, and the matching step of the running residue.
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
      rem_ge  = rem_sh >= {1'b0, den_ff};
      mod_sh  = {mod_ff, rem_ge};
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      mod_in  = mod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         quo_in  = '0;
         den_in  = divisor;
         rem_in  = '0;
         mod_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DVD_W-2:0], rem_ge};
         rem_in = rem_ge ? DATA_W'(rem_sh - {1'b0, den_ff}) : DATA_W'(rem_sh);
         mod_in = (mod_sh >= {1'b0, TWO_PI_Q}) ? MOD_W'(mod_sh - {1'b0, TWO_PI_Q})
                                               : MOD_W'(mod_sh);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      mod_ff <= mod_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign residue  = mod_ff;

endmodule

// File: design/pdi_cordic.sv
// ----------------------------------------------------------------------------
// Pendulum integrator CORDIC
// Rotation-mode CORDIC, one micro-rotation a cycle, giving the scaled sine.
// ----------------------------------------------------------------------------
module pdi_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [pdi_pkg::CORDIC_W-1:0] z_start,
   output logic                                done,
   output logic signed [pdi_pkg::CORDIC_W-1:0] y_out
);
   import pdi_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;
   logic [ROT_CNT_W-1:0]       cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic signed [CORDIC_W-1:0] dx, dy, da;

   // One micro-rotation towards zero residual angle.
   always_comb begin
      dx      = y_ff >>> cnt_ff;
      dy      = x_ff >>> cnt_ff;
      da      = atan_q30(6'(cnt_ff));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = z_start;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - da;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + da;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ROT_CNT_W'(SINE_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
   end

   assign done  = done_ff;
   assign y_out = y_ff;

endmodule

// File: design/pdi_datapath.sv
// ----------------------------------------------------------------------------
// Pendulum integrator datapath
// State registers, angle division, sine, shared multiply with saturating
// accumulate, sample bookkeeping and the result register.
// ----------------------------------------------------------------------------
module pdi_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  pdi_pkg::cmd_type                  cmd,
   output pdi_pkg::sts_type                  sts,
   input  logic [pdi_pkg::UREG_W-1:0]        gravity,
   input  logic [pdi_pkg::UREG_W-1:0]        rod_length,
   input  logic signed [pdi_pkg::DATA_W-1:0] start_position,
   input  logic signed [pdi_pkg::DATA_W-1:0] start_velocity,
   input  logic [pdi_pkg::UREG_W-1:0]        sample_step,
   input  logic [pdi_pkg::SUBS_W-1:0]        subdivisions,
   input  logic [pdi_pkg::CNT_W-1:0]         sample_count,
   output logic signed [pdi_pkg::DATA_W-1:0] rsp_position,
   output logic                              rsp_last_sample,
   output logic                              rsp_saturated
);
   import pdi_pkg::*;

   logic signed [DATA_W-1:0] pos_ff, pos_in, vel_ff, vel_in;
   logic signed [DATA_W-1:0] v2_ff, v2_in, sm_ff, sm_in, acc_ff, acc_in;
   logic signed [DATA_W-1:0] sin_ff, sin_in, dt_ff, dt_in, hdt_ff, hdt_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [DATA_W-1:0] snap_pos_ff, snap_pos_in;
   logic                     snap_last_ff, snap_last_in;
   logic                     clip_ff, clip_in;
   logic                     aneg_ff, aneg_in;
   logic                     sneg_ff, sneg_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic                     pneg_ff, pneg_in;
   logic signed [DATA_W-1:0] out_pos_ff, out_pos_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_sat_ff, out_sat_in;

   logic signed [DATA_W-1:0]   src_val;
   logic [DATA_W-1:0]          src_mag;
   logic [DVD_W-1:0]           div_dividend, div_quotient;
   logic [DATA_W-1:0]          div_divisor;
   logic [MOD_W-1:0]           div_residue;
   logic                       div_done;
   logic                       red_hi;
   logic [MOD_W-1:0]           ang_a, ang_b;
   logic signed [CORDIC_W-1:0] cordic_z0, cordic_y;
   logic                       cordic_done;
   logic                       y_neg;
   logic [CORDIC_W-1:0]        y_mag;
   logic [DATA_W-1:0]          sin_mag;
   logic signed [DATA_W-1:0]   sin_val;
   logic signed [DATA_W-1:0]   mul_a, mul_b;
   logic [DATA_W-1:0]          a_mag, b_mag;
   logic [Q_W-1:0]             q_full, q_lim, q_sat;
   logic                       mul_over;
   logic signed [DATA_W-1:0]   mval, acc_val, base_val, mac_val, fin_val;
   logic                       acc_over, add_over;
   logic signed [DATA_W:0]     sum;
   logic                       last_now;

   // Divider operands: angle quotient or substep time.
   always_comb begin
      src_val = (cmd.acc_src == AS_POS) ? pos_ff : sm_ff;
      src_mag = src_val[DATA_W-1] ? DATA_W'(-src_val) : DATA_W'(src_val);
      if (cmd.div_ang) begin
         div_dividend = {src_mag, FRAC_W'(0)};
         div_divisor  = (rod_length == '0) ? DATA_W'(1) : DATA_W'(rod_length);
      end else begin
         div_dividend = DVD_W'(sample_step);
         div_divisor  = (subdivisions == '0) ? DATA_W'(1) : DATA_W'(subdivisions);
      end
   end

   pdi_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient),
      .residue  (div_residue)
   );

   // Fold the reduced angle into the first quadrant.
   always_comb begin
      red_hi    = div_residue >= PI_Q;
      ang_a     = red_hi ? MOD_W'(div_residue - PI_Q) : div_residue;
      ang_b     = (ang_a > HALF_PI_Q) ? MOD_W'(PI_Q - ang_a) : ang_a;
      cordic_z0 = $signed(CORDIC_W'(ang_b) << (CORDIC_FRAC - FRAC_W));
   end

   pdi_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.cordic_start),
      .z_start (cordic_z0),
      .done    (cordic_done),
      .y_out   (cordic_y)
   );

   // Round the CORDIC output back to the data format and apply the sign.
   always_comb begin
      y_neg   = cordic_y[CORDIC_W-1];
      y_mag   = y_neg ? CORDIC_W'(-cordic_y) : CORDIC_W'(cordic_y);
      sin_mag = DATA_W'(y_mag >> (CORDIC_FRAC - FRAC_W))
              + DATA_W'(y_mag[CORDIC_FRAC-FRAC_W-1]);
      sin_val = (sneg_ff ^ y_neg) ? $signed(-sin_mag) : $signed(sin_mag);
   end

   // Multiplier operand selection, on magnitudes.
   always_comb begin
      unique case (cmd.mul_a)
         MA_GRAV: mul_a = $signed({1'b0, gravity});
         MA_ACC:  mul_a = acc_ff;
         MA_VEL:  mul_a = vel_ff;
         MA_V2:   mul_a = v2_ff;
         default: mul_a = acc_ff;
      endcase
      unique case (cmd.mul_b)
         MB_SIN:  mul_b = sin_ff;
         MB_DT:   mul_b = dt_ff;
         MB_HDT:  mul_b = hdt_ff;
         default: mul_b = dt_ff;
      endcase
      a_mag   = mul_a[DATA_W-1] ? DATA_W'(-mul_a) : DATA_W'(mul_a);
      b_mag   = mul_b[DATA_W-1] ? DATA_W'(-mul_b) : DATA_W'(mul_b);
      prod_in = PROD_W'(a_mag) * PROD_W'(b_mag);
      pneg_in = mul_a[DATA_W-1] ^ mul_b[DATA_W-1];
   end

   // Rescale and saturate the product, then negate or accumulate it.
   always_comb begin
      q_full   = prod_ff[PROD_W-1:FRAC_W];
      q_lim    = Q_W'(DATA_MAX) + Q_W'(pneg_ff);
      mul_over = q_full > q_lim;
      q_sat    = mul_over ? q_lim : q_full;
      mval     = pneg_ff ? $signed(-q_sat[DATA_W-1:0]) : $signed(q_sat[DATA_W-1:0]);
      acc_over = mval == DATA_MIN;
      acc_val  = acc_over ? DATA_MAX : -mval;
      base_val = (cmd.fin_base == B_POS) ? pos_ff : vel_ff;
      sum      = {base_val[DATA_W-1], base_val} + {mval[DATA_W-1], mval};
      add_over = sum[DATA_W] != sum[DATA_W-1];
      if (add_over) begin
         mac_val = sum[DATA_W] ? DATA_MIN : DATA_MAX;
      end else begin
         mac_val = sum[DATA_W-1:0];
      end
      fin_val = (cmd.fin_dest == D_ACC) ? acc_val : mac_val;
   end

   // Last-sample flag for the current index.
   assign last_now = (sample_count != '0) &&
                     (CNT_W'(idx_ff) == CNT_W'(sample_count - 1'b1));

   // Next values of the stored state.
   always_comb begin
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      v2_in        = v2_ff;
      sm_in        = sm_ff;
      acc_in       = acc_ff;
      sin_in       = sin_ff;
      dt_in        = dt_ff;
      hdt_in       = hdt_ff;
      idx_in       = idx_ff;
      snap_pos_in  = snap_pos_ff;
      snap_last_in = snap_last_ff;
      clip_in      = clip_ff;
      aneg_in      = aneg_ff;
      sneg_in      = sneg_ff;
      out_pos_in   = out_pos_ff;
      out_last_in  = out_last_ff;
      out_sat_in   = out_sat_ff;
      if (cmd.load_start) begin
         pos_in = start_position;
         vel_in = start_velocity;
         idx_in = '0;
      end
      if (cmd.dt_load) begin
         dt_in  = $signed({1'b0, div_quotient[DATA_W-2:0]});
         hdt_in = $signed({2'b0, div_quotient[DATA_W-2:1]});
      end
      if (cmd.snap) begin
         snap_pos_in  = pos_ff;
         snap_last_in = last_now;
         clip_in      = 1'b0;
         idx_in       = last_now ? '0 : idx_ff + 1'b1;
      end
      if (cmd.div_start && cmd.div_ang) begin
         aneg_in = src_val[DATA_W-1];
      end
      if (cmd.cordic_start) begin
         sneg_in = aneg_ff ^ red_hi;
      end
      if (cmd.sine_load) begin
         sin_in = sin_val;
      end
      if (cmd.fin_en) begin
         clip_in = clip_ff | mul_over |
                   ((cmd.fin_dest == D_ACC) ? acc_over : add_over);
         unique case (cmd.fin_dest)
            D_ACC:   acc_in = fin_val;
            D_VEL:   vel_in = fin_val;
            D_POS:   pos_in = fin_val;
            D_V2:    v2_in  = fin_val;
            D_SM:    sm_in  = fin_val;
            default: acc_in = fin_val;
         endcase
      end
      if (cmd.out_load) begin
         out_pos_in  = snap_pos_ff;
         out_last_in = snap_last_ff;
         out_sat_in  = clip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         vel_ff <= '0;
         dt_ff  <= '0;
         hdt_ff <= '0;
         idx_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         vel_ff <= vel_in;
         dt_ff  <= dt_in;
         hdt_ff <= hdt_in;
         idx_ff <= idx_in;
      end
      v2_ff        <= v2_in;
      sm_ff        <= sm_in;
      acc_ff       <= acc_in;
      sin_ff       <= sin_in;
      snap_pos_ff  <= snap_pos_in;
      snap_last_ff <= snap_last_in;
      clip_ff      <= clip_in;
      aneg_ff      <= aneg_in;
      sneg_ff      <= sneg_in;
      out_pos_ff   <= out_pos_in;
      out_last_ff  <= out_last_in;
      out_sat_ff   <= out_sat_in;
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
         pneg_ff <= pneg_in;
      end
   end

   assign sts.div_done    = div_done;
   assign sts.cordic_done = cordic_done;
   assign rsp_position    = out_pos_ff;
   assign rsp_last_sample = out_last_ff;
   assign rsp_saturated   = out_sat_ff;

endmodule

// File: design/pdi_ctrl.sv
// ----------------------------------------------------------------------------
// Pendulum integrator controller
// Sequences restart, sampling and the substep operations of either method,
// and owns both handshakes.
// ----------------------------------------------------------------------------
module pdi_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          method,
   input  logic [pdi_pkg::SUBS_W-1:0]    subdivisions,
   output pdi_pkg::cmd_type              cmd,
   input  pdi_pkg::sts_type              sts
);
   import pdi_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_SUBDIV   = 9'b000000010,
      ST_SNAP     = 9'b000000100,
      ST_DISPATCH = 9'b000001000,
      ST_ANG      = 9'b000010000,
      ST_ROT      = 9'b000100000,
      ST_MUL      = 9'b001000000,
      ST_FIN      = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [SUBS_W-1:0] sub_ff, sub_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic        op_accel, op_last;
   acc_src_type op_src;
   mul_a_type   op_a;
   mul_b_type   op_b;
   dest_type    op_dest;
   base_type    op_base;

   // Decode the current operation of the substep.
   always_comb begin
      op_accel = 1'b0;
      op_last  = 1'b0;
      op_src   = AS_POS;
      op_a     = MA_ACC;
      op_b     = MB_DT;
      op_dest  = D_VEL;
      op_base  = B_VEL;
      if (!method) begin
         case (op_ff)
            3'd0: op_accel = 1'b1;
            3'd1: begin
               op_a = MA_ACC; op_b = MB_DT; op_dest = D_VEL; op_base = B_VEL;
            end
            default: begin
               op_a = MA_VEL; op_b = MB_DT; op_dest = D_POS; op_base = B_POS;
               op_last = 1'b1;
            end
         endcase
      end else begin
         case (op_ff)
            3'd0: op_accel = 1'b1;
            3'd1: begin
               op_a = MA_ACC; op_b = MB_HDT; op_dest = D_V2; op_base = B_VEL;
            end
            3'd2: begin
               op_a = MA_V2; op_b = MB_HDT; op_dest = D_SM; op_base = B_POS;
            end
            3'd3: begin
               op_accel = 1'b1;
               op_src   = AS_SM;
            end
            3'd4: begin
               op_a = MA_ACC; op_b = MB_DT; op_dest = D_VEL; op_base = B_VEL;
            end
            default: begin
               op_a = MA_V2; op_b = MB_DT; op_dest = D_POS; op_base = B_POS;
               op_last = 1'b1;
            end
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sub_in       = sub_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.acc_src  = op_src;
      cmd.mul_a    = op_accel ? MA_GRAV : op_a;
      cmd.mul_b    = op_accel ? MB_SIN : op_b;
      cmd.fin_dest = op_accel ? D_ACC : op_dest;
      cmd.fin_base = op_base;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  cmd.load_start = 1'b1;
                  cmd.div_start  = 1'b1;
                  state_in       = ST_SUBDIV;
               end else begin
                  state_in = ST_SNAP;
               end
            end
         end
         ST_SUBDIV: begin
            if (sts.div_done) begin
               cmd.dt_load = 1'b1;
               state_in    = ST_SNAP;
            end
         end
         ST_SNAP: begin
            cmd.snap = 1'b1;
            sub_in   = (subdivisions == '0) ? SUBS_W'(1) : subdivisions;
            op_in    = '0;
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (op_accel) begin
               cmd.div_start = 1'b1;
               cmd.div_ang   = 1'b1;
               state_in      = ST_ANG;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_ANG: begin
            if (sts.div_done) begin
               cmd.cordic_start = 1'b1;
               state_in         = ST_ROT;
            end
         end
         ST_ROT: begin
            if (sts.cordic_done) begin
               cmd.sine_load = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin_en = 1'b1;
            if (op_last) begin
               if (sub_ff == SUBS_W'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  sub_in   = sub_ff - 1'b1;
                  op_in    = '0;
                  state_in = ST_DISPATCH;
               end
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      sub_ff <= sub_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/pdi_checker.sv
// ----------------------------------------------------------------------------
// Pendulum integrator port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "pendulum_ode_integrator_macros.svh"

module pdi_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [pdi_pkg::DATA_W-1:0] rsp_position,
   input logic                              rsp_last_sample,
   input logic                              rsp_saturated
);
   import pdi_pkg::*;

   // A waiting result stays put until it is taken.
   `PDI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_position) && $stable(rsp_last_sample) && $stable(rsp_saturated))

   // Out of reset the block holds no result and takes a request.
   `PDI_ASSERT_NEXT(a_reset_clean, clock, 1'b0, reset, !rsp_valid && req_ready)

   // One item at a time: taking a request closes the input side.
   `PDI_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)

   // A result appears only as the block returns to idle.
   `PDI_ASSERT_SAME(a_rsp_at_idle, clock, reset, $rose(rsp_valid), req_ready)

endmodule

bind pendulum_ode_integrator pdi_checker u_pdi_checker (.*);

// File: tb/tb_pendulum_ode_integrator.sv
// ----------------------------------------------------------------------------
// Pendulum integrator testbench
// Drives restart items through the valid/ready request channel and checks
// every result against a fixed-point predictor of the pendulum integrator.
// Configuration is changed between phases while the block is idle. A directed
// part covers the register extremes and the special cases. Random phases
// follow, with sender and receiver idling in three different patterns.
// ----------------------------------------------------------------------------
module tb_pendulum_ode_integrator;
   import pdi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint POS_LIMIT = 64'sd2147483647;

   typedef struct {
      logic signed [DATA_W-1:0] position;
      logic                     last_sample;
      logic                     saturated;
   } sample_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_restart;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_position;
   logic                     rsp_last_sample;
   logic                     rsp_saturated;
   logic                     csr_write_en;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [DATA_W-1:0]        csr_wdata;

   // Items waiting to be sent and samples waiting to come back.
   bit         pending_restarts[$];
   sample_type expected_samples[$];
   int         mismatch_count;
   int         send_gap_pct;
   int         stall_pct;

   // Shadow of the configuration registers.
   logic [UREG_W-1:0] gravity_cfg;
   logic [UREG_W-1:0] rod_cfg;
   logic [DATA_W-1:0] start_pos_cfg;
   logic [DATA_W-1:0] start_vel_cfg;
   logic [UREG_W-1:0] step_cfg;
   logic [SUBS_W-1:0] subs_cfg;
   logic              method_cfg;
   logic [CNT_W-1:0]  count_cfg;

   // Integrator state as predicted.
   longint            arc_pos;
   longint            arc_vel;
   longint            substep_dt;
   logic [IDX_W-1:0]  sample_idx;
   bit                clip_seen;

   pendulum_ode_integrator u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_position    (rsp_position),
      .rsp_last_sample (rsp_last_sample),
      .rsp_saturated   (rsp_saturated),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Saturation to the signed data range, noting any clip.
   function automatic longint clamp_data(longint v);
      if (v > POS_LIMIT) begin
         clip_seen = 1'b1;
         return POS_LIMIT;
      end
      if (v < -POS_LIMIT - 1) begin
         clip_seen = 1'b1;
         return -POS_LIMIT - 1;
      end
      return v;
   endfunction

   function automatic logic [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   // Drops n fraction bits, rounding half up.
   function automatic logic [63:0] round_down(logic [63:0] v, int n);
      return (v >> n) + ((v >> (n - 1)) & 64'd1);
   endfunction

   // Fixed-point product: magnitudes multiplied exactly, truncated, saturated.
   function automatic longint fixed_mul(longint a, longint b);
      bit           neg;
      logic [127:0] prod;
      logic [127:0] quot;
      logic [63:0]  lim;
      neg  = (a < 0) != (b < 0);
      prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      quot = prod >> FRAC_W;
      lim  = 64'h7FFF_FFFF + (neg ? 64'd1 : 64'd0);
      if (quot > {64'd0, lim}) begin
         clip_seen = 1'b1;
         quot = {64'd0, lim};
      end
      return neg ? -longint'(quot[63:0]) : longint'(quot[63:0]);
   endfunction

   function automatic longint arctan_step(int i);
      case (i)
         0: return 843314857;
         1: return 497837829;
         2: return 263043837;
         3: return 133525159;
         4: return 67021687;
         5: return 33543516;
         6: return 16775851;
         7: return 8388437;
         8: return 4194283;
         9: return 2097149;
         default: return (i <= CORDIC_FRAC) ? (64'sd1 <<< (CORDIC_FRAC - i)) : 0;
      endcase
   endfunction

   // Sine of s / rod, by range reduction and CORDIC rotations.
   function automatic longint pendulum_sine(longint s, logic [63:0] rod);
      logic [63:0] pi_c, two_pi_c, half_pi_c, ang, r;
      logic [79:0] quo;
      bit          neg, yneg;
      longint      x, y, z, dx, dy;
      int          iters;
      pi_c      = round_down(64'h3243F6A8885A308D, 60 - FRAC_W);
      two_pi_c  = round_down(64'h6487ED5110B4611A, 60 - FRAC_W);
      half_pi_c = round_down(64'h1921FB54442D1847, 60 - FRAC_W);
      if (rod == 0) rod = 64'd1;
      neg = s < 0;
      quo = {magnitude(s), 16'd0} / {16'd0, rod};
      ang = (quo[79:64] != 0) ? '1 : quo[63:0];
      ang = ang % two_pi_c;
      if (ang >= pi_c) begin
         ang = ang - pi_c;
         neg = !neg;
      end
      if (ang > half_pi_c) ang = pi_c - ang;
      z = longint'(ang << (CORDIC_FRAC - FRAC_W));
      x = 652032874;
      y = 0;
      iters = (SINE_ITERS < 48) ? SINE_ITERS : 48;
      for (int i = 0; i < iters; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arctan_step(i);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + arctan_step(i);
         end
      end
      yneg = y < 0;
      r = round_down(magnitude(y), CORDIC_FRAC - FRAC_W);
      return (neg != yneg) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint pendulum_accel(longint s);
      longint p;
      p = fixed_mul(longint'(gravity_cfg), pendulum_sine(s, 64'(rod_cfg)));
      if (p < -POS_LIMIT) begin
         clip_seen = 1'b1;
         return POS_LIMIT;
      end
      return -p;
   endfunction

   // Works out the sample for one item and advances the predicted state.
   function automatic sample_type next_sample(bit restart);
      sample_type  res;
      logic [63:0] subs;
      longint      dt, hdt, a1, v2, sm;
      bit          last;
      subs = (subs_cfg == 0) ? 64'd1 : 64'(subs_cfg);
      clip_seen = 1'b0;
      if (restart) begin
         arc_pos    = clamp_data(longint'($signed(start_pos_cfg)));
         arc_vel    = clamp_data(longint'($signed(start_vel_cfg)));
         substep_dt = longint'(64'(step_cfg) / subs);
         sample_idx = '0;
         clip_seen  = 1'b0;
      end
      last = (count_cfg != 0) && ({1'b0, sample_idx} == count_cfg - 1'b1);
      res.position    = arc_pos[DATA_W-1:0];
      res.last_sample = last;
      dt  = substep_dt;
      hdt = dt >>> 1;
      for (longint j = 0; j < longint'(subs); j++) begin
         if (!method_cfg) begin
            arc_vel = clamp_data(arc_vel + fixed_mul(pendulum_accel(arc_pos), dt));
            arc_pos = clamp_data(arc_pos + fixed_mul(arc_vel, dt));
         end else begin
            a1      = pendulum_accel(arc_pos);
            v2      = clamp_data(arc_vel + fixed_mul(hdt, a1));
            sm      = clamp_data(arc_pos + fixed_mul(hdt, v2));
            arc_vel = clamp_data(arc_vel + fixed_mul(pendulum_accel(sm), dt));
            arc_pos = clamp_data(arc_pos + fixed_mul(v2, dt));
         end
      end
      res.saturated = clip_seen;
      sample_idx = last ? '0 : sample_idx + 1'b1;
      return res;
   endfunction

   // Request driver: holds each item until it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_restart <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_restarts.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_valid   <= 1'b1;
            req_restart <= pending_restarts.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Prediction on each accepted item, then checking of each accepted result.
   always @(posedge clock) begin
      sample_type want;
      if (!reset) begin
         if (req_valid && req_ready) expected_samples.push_back(next_sample(req_restart));
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected result: position %0d", rsp_position);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_position !== want.position || rsp_last_sample !== want.last_sample ||
                   rsp_saturated !== want.saturated) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Mismatch: expected pos %0d last %0b sat %0b, got %0d %0b %0b",
                              want.position, want.last_sample, want.saturated,
                              rsp_position, rsp_last_sample, rsp_saturated);
               end
            end
         end
      end
   end

   // Register write, mirrored into the shadow copy.
   task automatic write_reg(csr_index_type idx, logic [DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         CSR_GRAVITY:        gravity_cfg   = data[UREG_W-1:0];
         CSR_ROD_LENGTH:     rod_cfg       = data[UREG_W-1:0];
         CSR_START_POSITION: start_pos_cfg = data;
         CSR_START_VELOCITY: start_vel_cfg = data;
         CSR_SAMPLE_STEP:    step_cfg      = data[UREG_W-1:0];
         CSR_SUBDIVISIONS:   subs_cfg      = data[SUBS_W-1:0];
         CSR_METHOD:         method_cfg    = data[0];
         CSR_SAMPLE_COUNT:   count_cfg     = data[CNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Waits until every item is sent and every result is back.
   // The check runs at the falling edge, once the driver and monitor have settled.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_restarts.size() != 0 || req_valid || expected_samples.size() != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic queue_items(bit restarts[$]);
      foreach (restarts[i]) pending_restarts.push_back(restarts[i]);
   endtask

   function automatic logic [DATA_W-1:0] pick_value(int small_span);
      if ($urandom_range(3) == 0) return $urandom;
      return DATA_W'($urandom_range(2 * small_span) - small_span);
   endfunction

   // Main sequence: reset, directed phases, random phases, then the verdict.
   initial begin
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      mismatch_count = 0;
      send_gap_pct   = 35;
      stall_pct      = 64;
      gravity_cfg    = 31'd642908;
      rod_cfg        = 31'd655360;
      start_pos_cfg  = 32'd65536;
      start_vel_cfg  = '0;
      step_cfg       = 31'd655;
      subs_cfg       = 16'd1;
      method_cfg     = 1'b0;
      count_cfg      = 21'd1024;
      arc_pos        = 0;
      arc_vel        = 0;
      substep_dt     = 0;
      sample_idx     = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: first from the zero state, then after a restart.
      queue_items('{0, 0, 0, 1, 0, 0, 0});
      wait_idle();

      // Largest values: huge angles, huge steps, saturation, one-sample runs.
      write_reg(CSR_GRAVITY, 32'h7FFF_FFFF);
      write_reg(CSR_ROD_LENGTH, 32'd1);
      write_reg(CSR_START_POSITION, 32'h7FFF_FFFF);
      write_reg(CSR_START_VELOCITY, 32'h8000_0000);
      write_reg(CSR_SAMPLE_STEP, 32'h7FFF_FFFF);
      write_reg(CSR_SUBDIVISIONS, 32'd2);
      write_reg(CSR_METHOD, 32'd1);
      write_reg(CSR_SAMPLE_COUNT, 32'd1);
      queue_items('{1, 0, 0});
      wait_idle();

      // Zero rod length, zero subdivisions, no gravity, last flag never set.
      write_reg(CSR_ROD_LENGTH, 32'd0);
      write_reg(CSR_GRAVITY, 32'd0);
      write_reg(CSR_START_POSITION, 32'h8000_0000);
      write_reg(CSR_START_VELOCITY, 32'h7FFF_FFFF);
      write_reg(CSR_SUBDIVISIONS, 32'd0);
      write_reg(CSR_METHOD, 32'd0);
      write_reg(CSR_SAMPLE_COUNT, 32'd0);
      queue_items('{1, 0});
      wait_idle();

      // Many substeps with midpoint, then a short run to see the index wrap.
      write_reg(CSR_SUBDIVISIONS, 32'hFFFF);
      write_reg(CSR_SAMPLE_COUNT, 32'h10_0000);
      write_reg(CSR_SUBDIVISIONS, 32'd200);
      write_reg(CSR_SAMPLE_STEP, 32'd65535);
      write_reg(CSR_GRAVITY, 32'd642908);
      write_reg(CSR_ROD_LENGTH, 32'd655360);
      write_reg(CSR_START_POSITION, 32'd100000);
      write_reg(CSR_START_VELOCITY, -32'sd50000);
      write_reg(CSR_METHOD, 32'd1);
      queue_items('{1, 0, 0});
      wait_idle();
      write_reg(CSR_METHOD, 32'd0);
      write_reg(CSR_SUBDIVISIONS, 32'd1);
      write_reg(CSR_SAMPLE_COUNT, 32'd3);
      queue_items('{1, 0, 0, 0, 0});
      wait_idle();

      // Random phases: each starts with a restart and mostly runs on freely.
      for (int phase = 0; phase < 8; phase++) begin
         if (phase < 3) begin
            send_gap_pct = 35;
            stall_pct    = 64;
         end else if (phase < 6) begin
            send_gap_pct = 64;
            stall_pct    = 35;
         end else begin
            send_gap_pct = 0;
            stall_pct    = 0;
         end
         write_reg(CSR_GRAVITY, ($urandom_range(3) == 0) ? $urandom : $urandom_range(2000000));
         write_reg(CSR_ROD_LENGTH, ($urandom_range(3) == 0) ? $urandom
                                                             : $urandom_range(2000000, 1));
         write_reg(CSR_START_POSITION, pick_value(300000));
         write_reg(CSR_START_VELOCITY, pick_value(300000));
         write_reg(CSR_SAMPLE_STEP, ($urandom_range(3) == 0) ? $urandom
                                                              : $urandom_range(30000, 1));
         write_reg(CSR_SUBDIVISIONS, $urandom_range(3, 1));
         write_reg(CSR_METHOD, $urandom_range(1));
         write_reg(CSR_SAMPLE_COUNT, ($urandom_range(9) == 0) ? 0 : $urandom_range(40, 1));
         pending_restarts.push_back(1'b1);
         for (int n = 1; n < 125; n++) pending_restarts.push_back($urandom_range(19) == 0);
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[pendulum_ode_integrator] OK");
      end else begin
         $display("[pendulum_ode_integrator] ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #50_000_000;
      $display("[pendulum_ode_integrator] ERROR");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/pdi_pkg.sv
design/pdi_divider.sv
design/pdi_cordic.sv
design/pdi_datapath.sv
design/pdi_ctrl.sv
design/pendulum_ode_integrator.sv
design/pdi_checker.sv
tb/tb_pendulum_ode_integrator.sv
